FILE: sv/ellgen_pkg.sv
// Shared types and constants for the ellipse point generator.
// Holds the sequencer state encoding and the control and status structs.
// No dependencies.
package ellgen_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;

  // Values of the item kind carried on the input tuser.
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_SA,
    S_ST_SB,
    S_ST_SQ,
    S_ST_SA2,
    S_SR_T,
    S_SR_TT,
    S_SR_CMP,
    S_ST_DEC,
    S_ST_FIN,
    S_ADV_M1,
    S_ADV_M2,
    S_ADV_FIN,
    S_R2_ENT,
    S_R2_EFIN,
    S_OUT
  } state_e;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic s_valid;
    logic kind;
    logic busy;
    logic region_two;
    logic x_le_p;
    logic t_le_a;
    logic bit_last;
    logic out_free;
  } status_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    state_e state;
    logic   take_item;
    logic   out_load;
  } ctrl_t;

endpackage

FILE: sv/ellgen_mul.sv
// Shared signed multiplier with a registered product.
// Every multiply of the generator goes through this one unit.
// No dependencies.
module ellgen_mul #(
  parameter int unsigned W = 22
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   op_a_i,
  input  logic signed [W-1:0]   op_b_i,
  output logic signed [2*W-1:0] prod_o
);

  logic signed [2*W-1:0] prod_q;
  logic signed [2*W-1:0] prod_d;

  assign prod_d = op_a_i * op_b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: sv/ellgen_seq.sv
// Sequencer of the ellipse point generator.
// Steps the shared multiplier through setup, boundary search and point steps.
// Depends on ellgen_pkg.
module ellgen_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ellgen_pkg::status_t status_i,
  output ellgen_pkg::ctrl_t   ctrl_o
);
  import ellgen_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (status_i.s_valid) begin
          if (status_i.kind == KIND_START) begin
            state_d = S_ST_SA;
          end else if (!status_i.busy) begin
            state_d = S_IDLE;
          end else if (status_i.region_two) begin
            state_d = status_i.x_le_p ? S_IDLE : S_ADV_M1;
          end else begin
            state_d = status_i.x_le_p ? S_ADV_M1 : S_R2_ENT;
          end
        end
      end
      S_ST_SA:   state_d = S_ST_SB;
      S_ST_SB:   state_d = S_ST_SQ;
      S_ST_SQ:   state_d = S_ST_SA2;
      S_ST_SA2:  state_d = S_SR_T;
      S_SR_T: begin
        if (status_i.t_le_a) begin
          state_d = S_SR_TT;
        end else begin
          state_d = status_i.bit_last ? S_ST_DEC : S_SR_T;
        end
      end
      S_SR_TT:   state_d = S_SR_CMP;
      S_SR_CMP:  state_d = status_i.bit_last ? S_ST_DEC : S_SR_T;
      S_ST_DEC:  state_d = S_ST_FIN;
      S_ST_FIN:  state_d = S_OUT;
      S_ADV_M1:  state_d = S_ADV_M2;
      S_ADV_M2:  state_d = S_ADV_FIN;
      S_ADV_FIN: state_d = S_OUT;
      S_R2_ENT:  state_d = S_R2_EFIN;
      S_R2_EFIN: state_d = S_OUT;
      S_OUT:     state_d = status_i.out_free ? S_IDLE : S_OUT;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.state     = state_q;
    ctrl_o.take_item = (state_q == S_IDLE) && status_i.s_valid;
    ctrl_o.out_load  = (state_q == S_OUT) && status_i.out_free;
  end

endmodule

FILE: sv/ellipse_point_generator.sv
// Top level of the ellipse point generator: stream ports, datapath registers
// and output register. Depends on ellgen_pkg, ellgen_mul and ellgen_seq.
//
//   port group | direction | tdata                        | tuser  | tlast
//   s_axis     | in        | semi_axis_a, semi_axis_b     | kind   | -
//   m_axis     | out       | point_x, point_y             | region | last_point
//
// An advance item runs two multiplies on the single shared multiplier, then the
// update and the output load; the step into region two runs one multiply, and
// an advance that yields no point leaves the sequencer idle. A start item is
// dominated by the boundary search, which visits S_SR_T alone for each bit above
// a and S_SR_T, S_SR_TT and S_SR_CMP for each bit that needs the two multiplies.
// Input is taken only in the idle state; a finished point waits in the output
// register, so a stalled output holds the next item back only once it is full.
// Reset leaves no ellipse active; advances then produce no transfer.
module ellipse_point_generator #(
  parameter int unsigned COORD_BITS = ellgen_pkg::COORD_BITS_DEF,
  localparam int unsigned DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // semi_axis_a, semi_axis_b, zero pad
  input  logic [0:0]        s_axis_tuser_i,  // kind
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,  // point_x, point_y, zero pad
  output logic [0:0]        m_axis_tuser_o,  // region
  output logic              m_axis_tlast_o   // last_point
);
  import ellgen_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned XW = CB + 2;          // signed coordinate
  localparam int unsigned MW = 2 * CB + 2;      // multiplier operand
  localparam int unsigned DW = 2 * MW;          // decision and product
  localparam int unsigned BW = $clog2(CB);

  status_t status;
  ctrl_t   ctrl;

  // Item and ellipse registers.
  logic [CB-1:0]        a_q, b_q;
  logic [2*CB-1:0]      sa_q, sb_q;
  logic [4*CB-1:0]      sa2_q;
  logic [CB-1:0]        p_q;
  logic [BW-1:0]        bit_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [DW-1:0] dec_q;
  logic                 dneg_q;
  logic                 last_q;
  logic                 busy_q, region_two_q;

  logic [CB-1:0]        out_x_q, out_y_q;
  logic                 out_region_q, out_last_q, out_valid_q;

  // Multiplier operands and product.
  logic signed [MW-1:0] op_a, op_b;
  logic signed [DW-1:0] prod;

  logic [2*CB:0]        s_sum;
  logic [CB-1:0]        t_val;
  logic signed [XW:0]   x2p3, y2p3;
  logic signed [XW-1:0] x_dec, y_dec, x_inc, y_inc, x_new2;
  logic signed [XW-1:0] p_s;
  logic signed [DW-1:0] sa_d, sb_d, prod2, prod4;
  logic                 prod_le;
  logic                 last2;

  assign s_sum  = {1'b0, sa_q} + {1'b0, sb_q};
  assign t_val  = p_q | (CB'(1) << bit_q);
  assign x2p3   = {x_q, 1'b0} + (XW + 1)'(3);
  assign y2p3   = {y_q, 1'b0} + (XW + 1)'(3);
  assign x_dec  = x_q - XW'(1);
  assign y_dec  = y_q - XW'(1);
  assign x_inc  = x_q + XW'(1);
  assign y_inc  = y_q + XW'(1);
  assign p_s    = {2'b00, p_q};
  assign x_new2 = dneg_q ? x_q : x_dec;
  assign last2  = x_new2 <= p_s;
  assign sa_d   = DW'(sa_q);
  assign sb_d   = DW'(sb_q);
  assign prod2  = {prod[DW-2:0], 1'b0};
  assign prod4  = {prod[DW-3:0], 2'b00};
  assign prod_le = prod[4*CB:0] <= {1'b0, sa2_q};

  // Clamp a signed coordinate into the output field.
  function automatic logic [CB-1:0] sat_field(input logic signed [XW-1:0] v);
    logic [CB-1:0] r;
    if (v[XW-1]) begin
      r = '0;
    end else if (v[CB]) begin
      r = '1;
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.state)
      S_ST_SA: begin
        op_a = MW'(a_q);
        op_b = MW'(a_q);
      end
      S_ST_SB: begin
        op_a = MW'(b_q);
        op_b = MW'(b_q);
      end
      S_ST_SQ: begin
        op_a = MW'(sa_q);
        op_b = MW'(sa_q);
      end
      S_SR_T: begin
        op_a = MW'(t_val);
        op_b = MW'(t_val);
      end
      S_SR_TT: begin
        op_a = MW'(prod[2*CB-1:0]);
        op_b = MW'(s_sum);
      end
      S_ST_DEC: begin
        op_a = MW'(b_q);
        op_b = MW'(sa_q);
      end
      S_R2_ENT: begin
        op_a = MW'(a_q);
        op_b = MW'(sb_q);
      end
      S_ADV_M1: begin
        // Region two steps y and region one steps x, with the squares swapped.
        if (region_two_q) begin
          op_a = MW'(sa_q);
          op_b = MW'(y2p3);
        end else begin
          op_a = MW'(sb_q);
          op_b = MW'(x2p3);
        end
      end
      S_ADV_M2: begin
        if (region_two_q) begin
          op_a = MW'(sb_q);
          op_b = MW'(x_dec);
        end else begin
          op_a = MW'(sa_q);
          op_b = MW'(y_dec);
        end
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ellgen_mul #(
    .W (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  always_comb begin
    status.s_valid    = s_axis_tvalid_i;
    status.kind       = s_axis_tuser_i[0];
    status.busy       = busy_q;
    status.region_two = region_two_q;
    status.x_le_p     = x_q <= p_s;
    status.t_le_a     = t_val <= a_q;
    status.bit_last   = bit_q == '0;
    status.out_free   = !out_valid_q || m_axis_tready_i;
  end

  ellgen_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      region_two_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctrl.take_item) begin
        if (s_axis_tuser_i[0] == KIND_START) begin
          region_two_q <= 1'b0;
        end else if (region_two_q && status.x_le_p) begin
          busy_q <= 1'b0;
        end
      end
      case (ctrl.state)
        S_ST_FIN: busy_q <= 1'b1;
        S_R2_EFIN: begin
          region_two_q <= 1'b1;
          if (a_q <= p_q) begin
            busy_q <= 1'b0;
          end
        end
        S_ADV_FIN: begin
          if (region_two_q && last2) begin
            busy_q <= 1'b0;
          end
        end
        default: ;
      endcase
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctrl.take_item && s_axis_tuser_i[0] == KIND_START) begin
      a_q <= s_axis_tdata_i[CB-1:0];
      b_q <= s_axis_tdata_i[2*CB-1:CB];
    end
    case (ctrl.state)
      S_ST_SB:  sa_q <= prod[2*CB-1:0];
      S_ST_SQ:  sb_q <= prod[2*CB-1:0];
      S_ST_SA2: begin
        sa2_q <= prod[4*CB-1:0];
        p_q   <= '0;
        bit_q <= BW'(CB - 1);
      end
      S_SR_T: begin
        if (!status.t_le_a) begin
          bit_q <= bit_q - BW'(1);
        end
      end
      S_SR_CMP: begin
        if (prod_le) begin
          p_q <= t_val;
        end
        bit_q <= bit_q - BW'(1);
      end
      S_ST_FIN: begin
        dec_q  <= {sb_d[DW-2:0], 1'b0} - prod2 + sa_d;
        x_q    <= '0;
        y_q    <= XW'(b_q);
        last_q <= 1'b0;
      end
      S_R2_EFIN: begin
        dec_q  <= {sa_d[DW-2:0], 1'b0} - prod2 + sb_d;
        x_q    <= XW'(a_q);
        y_q    <= '0;
        last_q <= a_q <= p_q;
      end
      S_ADV_M1: dneg_q <= dec_q[DW-1];
      S_ADV_M2: dec_q  <= dec_q + prod2;
      S_ADV_FIN: begin
        if (!dneg_q) begin
          dec_q <= dec_q - prod4;
        end
        if (region_two_q) begin
          x_q    <= x_new2;
          y_q    <= y_inc;
          last_q <= last2;
        end else begin
          x_q    <= x_inc;
          if (!dneg_q) begin
            y_q <= y_dec;
          end
          last_q <= 1'b0;
        end
      end
      default: ;
    endcase
    if (ctrl.out_load) begin
      out_x_q      <= sat_field(x_q);
      out_y_q      <= sat_field(y_q);
      out_region_q <= region_two_q;
      out_last_q   <= last_q;
    end
  end

  assign s_axis_tready_o   = ctrl.state == S_IDLE;
  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = DATA_W'({out_y_q, out_x_q});
  assign m_axis_tuser_o[0] = out_region_q;
  assign m_axis_tlast_o    = out_last_q;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for ellipse_point_generator: stream stimulus with random
// gaps and output stalls, checked against an in-bench ellipse stepper.
// Depends on ellgen_pkg and the ellipse_point_generator RTL.
module tb_top;
  import ellgen_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW     = COORD_BITS_DEF;
  localparam int DATA_W = ((2 * CW + 7) / 8) * 8;

  typedef struct {
    logic          kind;
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    int unsigned   gap;     // idle cycles after this transfer
    bit            drain;   // hold off until every expected point has arrived
  } stim_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          region;
    logic          last;
  } ellipse_point_t;

  logic              clk_i;
  logic              rst_ni;
  logic              tx_valid;
  logic              tx_ready;
  logic [DATA_W-1:0] tx_data;
  logic [0:0]        tx_kind;
  logic              rx_valid;
  logic              rx_ready;
  logic [DATA_W-1:0] rx_data;
  logic [0:0]        rx_region;
  logic              rx_last;

  stim_t          stim_q[$];
  ellipse_point_t expected_points[$];
  stim_t          cur_item;
  int unsigned    tx_wait;
  int unsigned    rx_wait;
  int unsigned    rx_draw;
  bit             rx_steady;
  bit             gen_steady;
  int             items_queued;
  int             mismatches;

  // Stepper state: current point, decision term, squared axes and boundary.
  longint trace_x, trace_y, trace_d, trace_a, trace_p, asq, bsq;
  bit     trace_r2, trace_on;

  ellipse_point_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(tx_valid),
    .s_axis_tready_o(tx_ready),
    .s_axis_tdata_i (tx_data),    // semi_axis_a, semi_axis_b, zero pad
    .s_axis_tuser_i (tx_kind),    // kind
    .m_axis_tvalid_o(rx_valid),
    .m_axis_tready_i(rx_ready),
    .m_axis_tdata_o (rx_data),    // point_x, point_y, zero pad
    .m_axis_tuser_o (rx_region),  // region
    .m_axis_tlast_o (rx_last)     // last_point
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Largest p not above a with p*p*(asq+bsq) <= asq*asq, built bit by bit.
  function automatic longint boundary_search(longint a, longint sa, longint sb);
    longint q, p, t;
    int     i;
    if (sa + sb == 0) return 0;
    q = (sa * sa) / (sa + sb);
    p = 0;
    for (i = CW; i >= 0; i--) begin
      t = p | (longint'(1) << i);
      if (t <= a && t * t <= q) p = t;
    end
    return p;
  endfunction

  function automatic logic [CW-1:0] clip_coord(longint v);
    if (v < 0) return '0;
    if (v > longint'((1 << CW) - 1)) return '1;
    return v[CW-1:0];
  endfunction

  task automatic push_point(logic region, logic last);
    ellipse_point_t p;
    p.x      = clip_coord(trace_x);
    p.y      = clip_coord(trace_y);
    p.region = region;
    p.last   = last;
    expected_points.push_back(p);
  endtask

  task automatic step_ellipse(logic kind, logic [CW-1:0] a_in, logic [CW-1:0] b_in);
    longint b;
    if (kind == KIND_START) begin
      trace_a  = a_in;
      b        = b_in;
      asq      = trace_a * trace_a;
      bsq      = b * b;
      trace_p  = boundary_search(trace_a, asq, bsq);
      trace_x  = 0;
      trace_y  = b;
      trace_d  = 2 * bsq - 2 * b * asq + asq;
      trace_r2 = 1'b0;
      trace_on = 1'b1;
      push_point(1'b0, 1'b0);
    end else if (trace_on) begin
      if (!trace_r2) begin
        if (trace_x <= trace_p) begin
          if (trace_d < 0) begin
            trace_d += 2 * bsq * (2 * trace_x + 3);
          end else begin
            trace_d += 2 * bsq * (2 * trace_x + 3) - 4 * asq * (trace_y - 1);
            trace_y--;
          end
          trace_x++;
          push_point(1'b0, 1'b0);
        end else begin
          // Region two restarts from the end of the horizontal axis.
          trace_r2 = 1'b1;
          trace_x  = trace_a;
          trace_y  = 0;
          trace_d  = 2 * asq - 2 * trace_a * bsq + bsq;
          trace_on = trace_x > trace_p;
          push_point(1'b1, !trace_on);
        end
      end else if (trace_x > trace_p) begin
        if (trace_d < 0) begin
          trace_d += 2 * asq * (2 * trace_y + 3);
        end else begin
          trace_d += 2 * asq * (2 * trace_y + 3) - 4 * bsq * (trace_x - 1);
          trace_x--;
        end
        trace_y++;
        trace_on = trace_x > trace_p;
        push_point(1'b1, !trace_on);
      end else begin
        trace_on = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("%0d ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_point();
    ellipse_point_t want;
    logic [CW-1:0]  got_x, got_y;
    got_x = rx_data[CW-1:0];
    got_y = rx_data[2*CW-1:CW];
    if (expected_points.size() == 0) begin
      report_mismatch($sformatf("unexpected point (%0d,%0d)", got_x, got_y));
      return;
    end
    want = expected_points.pop_front();
    if (got_x !== want.x)
      report_mismatch($sformatf("point_x got %0d want %0d", got_x, want.x));
    if (got_y !== want.y)
      report_mismatch($sformatf("point_y got %0d want %0d", got_y, want.y));
    if (rx_region !== want.region)
      report_mismatch($sformatf("region got %0b want %0b", rx_region, want.region));
    if (rx_last !== want.last)
      report_mismatch($sformatf("last_point got %0b want %0b", rx_last, want.last));
  endtask

  // Input driver: predicts on every accepted transfer, then presents the next item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid <= 1'b0;
      tx_data  <= '0;
      tx_kind  <= KIND_ADVANCE;
      tx_wait  <= 0;
    end else begin
      if (tx_valid && tx_ready) step_ellipse(tx_kind[0], tx_data[CW-1:0], tx_data[2*CW-1:CW]);
      if (tx_valid && !tx_ready) begin
        // Hold the item until it is taken.
      end else if (tx_wait != 0) begin
        tx_wait  <= tx_wait - 1;
        tx_valid <= 1'b0;
      end else if (stim_q.size() != 0 &&
                   (!stim_q[0].drain || expected_points.size() == 0)) begin
        cur_item = stim_q.pop_front();
        tx_data  <= {{(DATA_W - 2 * CW){1'b0}}, cur_item.b, cur_item.a};
        tx_kind  <= cur_item.kind;
        tx_valid <= 1'b1;
        tx_wait  <= cur_item.gap;
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  // Output monitor with random back-pressure, switched off for stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready  <= 1'b0;
      rx_wait   <= 0;
      rx_steady <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      check_point();
      rx_draw = rx_steady ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 19) == 0) rx_steady <= !rx_steady;
      rx_wait  <= rx_draw;
      rx_ready <= (rx_draw == 0);
    end else begin
      if (rx_wait != 0) rx_wait <= rx_wait - 1;
      rx_ready <= (rx_wait <= 1);
    end
  end

  task automatic queue_item(logic kind, int a, int b, bit drain);
    stim_t s;
    s.kind  = kind;
    s.a     = CW'(a);
    s.b     = CW'(b);
    s.drain = drain;
    s.gap   = gen_steady ? 0 : $urandom_range(0, 4);
    stim_q.push_back(s);
    items_queued++;
  endtask

  task automatic queue_advances(int n);
    repeat (n) queue_item(KIND_ADVANCE, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0);
  endtask

  initial begin
    int a, b, pick, span;
    bit drain;
    mismatches   = 0;
    items_queued = 0;
    gen_steady   = 1'b0;
    rst_ni       = 1'b0;

    // Directed: advances while idle, the smallest ellipse traced past its end,
    // zero axes, and restarts that drop a running ellipse at the axis extremes.
    queue_advances(2);
    queue_item(KIND_START, 1, 1, 1'b0);
    queue_advances(5);
    queue_item(KIND_START, 0, 0, 1'b0);
    queue_advances(3);
    queue_item(KIND_START, 0, 3, 1'b0);
    queue_advances(3);
    queue_item(KIND_START, 3, 0, 1'b0);
    queue_advances(5);
    queue_item(KIND_START, 1023, 1023, 1'b0);
    queue_advances(2);
    queue_item(KIND_START, 1023, 1, 1'b0);
    queue_advances(1);
    queue_item(KIND_START, 1, 1023, 1'b0);
    queue_advances(1);

    // Random: mostly complete traces of small ellipses, some cut short by a
    // new start, and a little noise.
    while (items_queued < 630) begin
      pick  = $urandom_range(0, 99);
      drain = ($urandom_range(0, 24) == 0) || (items_queued < 40);
      if ($urandom_range(0, 9) == 0) gen_steady = !gen_steady;
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else begin
        a = $urandom_range(1, 24);
        b = $urandom_range(1, 24);
      end
      if (pick < 70 && a + b <= 60) begin
        queue_item(KIND_START, a, b, drain);
        queue_advances(a + b + 3 + $urandom_range(0, 2));
      end else if (pick < 90) begin
        span = (a + b < 12) ? a + b : 12;
        queue_item(KIND_START, a, b, drain);
        queue_advances($urandom_range(0, span));
      end else if (pick < 95) begin
        queue_advances($urandom_range(1, 3));
      end else begin
        queue_item(KIND_START, a, b, drain);
      end
    end

    // The widest flat ellipse stepped for a while: y runs well below zero with a
    // large decision term, so the lower end of the output clipping is exercised.
    gen_steady = 1'b0;
    queue_item(KIND_START, 1023, 0, 1'b1);
    queue_advances(40);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || tx_valid || expected_points.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ellipse_point_generator: match");
    end else begin
      $display("ellipse_point_generator: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ellipse_point_generator: mismatch");
    $finish;
  end

endmodule

FILE: files.f
sv/ellgen_pkg.sv
sv/ellgen_mul.sv
sv/ellgen_seq.sv
sv/ellipse_point_generator.sv
test/tb_top.sv
